FILE: rtl/utf8ww_pkg.sv
// Shared types and constants of the UTF-8 word-wrap paginator.
// Beat structs for both channels, decoder-to-layout structs, config indexes.
// No dependencies.
package utf8ww_pkg;

    // Page cap and the width of the page counter that follows from it
    localparam int MAX_PAGES = 16384;
    localparam int PAGE_W    = $clog2(MAX_PAGES + 1);

    // Register reset values
    localparam logic [7:0] LINE_COLUMNS_RST = 8'd38;
    localparam logic [7:0] PAGE_ROWS_RST    = 8'd27;

    // Configuration register indexes
    localparam logic CFG_LINE_COLUMNS = 1'b0;
    localparam logic CFG_PAGE_ROWS    = 1'b1;

    // UTF-8 byte classes
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] TAG_CONT  = 8'h80;
    localparam logic [7:0] MASK_LD2  = 8'hE0;
    localparam logic [7:0] TAG_LD2   = 8'hC0;
    localparam logic [7:0] MASK_LD3  = 8'hF0;
    localparam logic [7:0] TAG_LD3   = 8'hE0;
    localparam logic [7:0] MASK_LD4  = 8'hF8;
    localparam logic [7:0] TAG_LD4   = 8'hF0;

    // Code points that steer the wrapper
    localparam logic [15:0] CP_LF    = 16'h000A;
    localparam logic [15:0] CP_SPACE = 16'h0020;
    localparam logic [15:0] CP_TAB   = 16'h0009;
    localparam logic [15:0] CP_CR    = 16'h000D;
    localparam logic [15:0] CP_QMARK = 16'h003F;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] page_offset;
        logic        last_of_run;
    } t_out_beat;

    typedef enum logic [1:0] {
        CH_OTHER = 2'd0,
        CH_BLANK = 2'd1,
        CH_LF    = 2'd2
    } t_char_kind;

    // One decoded character: its class and how many bytes back it started
    typedef struct packed {
        logic       valid;
        t_char_kind kind;
        logic [1:0] back;
    } t_char;

    // Page breaks caused by one byte
    typedef struct packed {
        logic [1:0]  cnt;
        logic [31:0] off0;
        logic [31:0] off1;
    } t_brk;

endpackage

FILE: rtl/utf8ww_decode.sv
// UTF-8 decoder: holds the pending multi-byte sequence, emits at most one character event per byte.
// Depends on utf8ww_pkg.
module utf8ww_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output utf8ww_pkg::t_char     o_char
);

    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [1:0]  r_count, n_count;
    logic [1:0]  r_need, n_need;
    logic [15:0] cp;
    logic        handled;
    utf8ww_pkg::t_char ch;

    // Sequence tracking and code point assembly
    always_comb begin
        n_lead   = r_lead;
        n_second = r_second;
        n_count  = r_count;
        n_need   = r_need;
        handled  = 1'b0;
        cp       = '0;
        ch.valid = 1'b0;
        ch.back  = 2'd0;
        if (r_need != 2'd0) begin
            if ((i_byte & utf8ww_pkg::MASK_CONT) == utf8ww_pkg::TAG_CONT) begin
                handled = 1'b1;
                if (r_count == r_need) begin
                    ch.valid = 1'b1;
                    ch.back  = r_need;
                    unique case (r_need)
                        2'd1: cp = {5'd0, r_lead[4:0], i_byte[5:0]};
                        2'd2: cp = {r_lead[3:0], r_second[5:0], i_byte[5:0]};
                        default: cp = utf8ww_pkg::CP_QMARK;
                    endcase
                    n_need  = 2'd0;
                    n_count = 2'd0;
                end else begin
                    if (r_count == 2'd1) begin
                        n_second = i_byte;
                    end
                    n_count = r_count + 2'd1;
                end
            end else begin
                // broken sequence: drop it, byte is handled fresh below
                n_need  = 2'd0;
                n_count = 2'd0;
            end
        end
        if (!handled) begin
            if (!i_byte[7]) begin
                ch.valid = 1'b1;
                ch.back  = 2'd0;
                cp       = {8'd0, i_byte};
            end else if ((i_byte & utf8ww_pkg::MASK_LD2) == utf8ww_pkg::TAG_LD2) begin
                n_lead = i_byte; n_count = 2'd1; n_need = 2'd1;
            end else if ((i_byte & utf8ww_pkg::MASK_LD3) == utf8ww_pkg::TAG_LD3) begin
                n_lead = i_byte; n_count = 2'd1; n_need = 2'd2;
            end else if ((i_byte & utf8ww_pkg::MASK_LD4) == utf8ww_pkg::TAG_LD4) begin
                n_lead = i_byte; n_count = 2'd1; n_need = 2'd3;
            end
        end
        // character class
        if (cp == utf8ww_pkg::CP_LF) begin
            ch.kind = utf8ww_pkg::CH_LF;
        end else if (cp == utf8ww_pkg::CP_SPACE || cp == utf8ww_pkg::CP_TAB ||
                     cp == utf8ww_pkg::CP_CR) begin
            ch.kind = utf8ww_pkg::CH_BLANK;
        end else begin
            ch.kind = utf8ww_pkg::CH_OTHER;
        end
        // end of document drops any incomplete sequence
        if (i_last) begin
            n_lead   = 8'd0;
            n_second = 8'd0;
            n_count  = 2'd0;
            n_need   = 2'd0;
        end
    end

    assign o_char = ch;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_need  <= 2'd0;
        end else if (i_adv) begin
            r_count <= n_count;
            r_need  <= n_need;
        end
    end

    // Sequence bytes
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lead   <= n_lead;
            r_second <= n_second;
        end
    end

    a_pend_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need != 2'd0) |-> (r_count != 2'd0 && r_count <= r_need))
        else $error("pending count out of range");

endmodule

FILE: rtl/utf8ww_layout.sv
// Greedy word wrap and pagination: column, line, word and page counters.
// Consumes decoder character events. Depends on utf8ww_pkg.
module utf8ww_layout (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  utf8ww_pkg::t_char     i_char,
    input  logic                  i_last,
    input  logic [7:0]            i_line_columns,
    input  logic [7:0]            i_page_rows,
    output utf8ww_pkg::t_brk      o_brk
);

    typedef struct packed {
        logic [7:0]                   col;
        logic [7:0]                   line;
        logic [7:0]                   wc;
        logic [31:0]                  ws;
        logic [utf8ww_pkg::PAGE_W-1:0] pages;
        logic [1:0]                   cnt;
        logic [31:0]                  off0;
        logic [31:0]                  off1;
    } t_lay;

    logic [31:0]                   r_byte_offset;
    logic [7:0]                    r_col;
    logic [7:0]                    r_line;
    logic [7:0]                    r_wc;
    logic [31:0]                   r_ws;
    logic [utf8ww_pkg::PAGE_W-1:0] r_pages;
    logic [31:0]                   end_off;
    t_lay                          s;

    // Record a page break unless past the document end or at the cap
    function automatic t_lay f_note(t_lay st, logic [31:0] off, logic last,
                                    logic [31:0] eoff);
        t_lay r;
        r = st;
        if (!(last && off >= eoff) &&
            st.pages < utf8ww_pkg::PAGE_W'(utf8ww_pkg::MAX_PAGES)) begin
            r.pages = st.pages + 1'b1;
            if (st.cnt == 2'd0) begin
                r.off0 = off;
                r.cnt  = 2'd1;
            end else if (st.cnt == 2'd1) begin
                r.off1 = off;
                r.cnt  = 2'd2;
            end
        end
        return r;
    endfunction

    function automatic t_lay f_end_line(t_lay st, logic [31:0] nxt, logic [7:0] pr,
                                        logic last, logic [31:0] eoff);
        t_lay       r;
        logic [8:0] ln;
        r     = st;
        ln    = {1'b0, st.line} + 9'd1;
        r.col = 8'd0;
        if (ln >= {1'b0, pr}) begin
            r.line = 8'd0;
            r      = f_note(r, nxt, last, eoff);
        end else begin
            r.line = ln[7:0];
        end
        return r;
    endfunction

    function automatic t_lay f_place(t_lay st, logic [7:0] lc, logic [7:0] pr,
                                     logic last, logic [31:0] eoff);
        t_lay       r;
        logic [9:0] fit;
        r   = st;
        fit = {2'b0, st.col} + 10'd1 + {2'b0, st.wc};
        if (st.wc != 8'd0) begin
            if (st.col != 8'd0 && fit > {2'b0, lc}) begin
                r = f_end_line(r, st.ws, pr, last, eoff);
            end
            if (r.col != 8'd0) begin
                r.col = fit[7:0];
            end else begin
                r.col = st.wc;
            end
            r.wc = 8'd0;
        end
        return r;
    endfunction

    // One byte's worth of layout: the character, then the end-of-document flush
    always_comb begin
        end_off = r_byte_offset + 32'd1;
        s.col   = r_col;
        s.line  = r_line;
        s.wc    = r_wc;
        s.ws    = r_ws;
        s.pages = r_pages;
        s.cnt   = 2'd0;
        s.off0  = '0;
        s.off1  = '0;
        if (i_char.valid) begin
            unique case (i_char.kind)
                utf8ww_pkg::CH_LF: begin
                    s = f_place(s, i_line_columns, i_page_rows, i_last, end_off);
                    s = f_end_line(s, end_off, i_page_rows, i_last, end_off);
                end
                utf8ww_pkg::CH_BLANK: begin
                    s = f_place(s, i_line_columns, i_page_rows, i_last, end_off);
                end
                default: begin
                    if (s.wc == 8'd0) begin
                        s.ws = r_byte_offset - {30'd0, i_char.back};
                    end
                    s.wc = s.wc + 8'd1;
                    if (s.wc >= i_line_columns) begin
                        s = f_place(s, i_line_columns, i_page_rows, i_last, end_off);
                    end
                end
            endcase
        end
        if (i_last) begin
            s = f_place(s, i_line_columns, i_page_rows, i_last, end_off);
            if (s.col != 8'd0) begin
                s = f_end_line(s, end_off, i_page_rows, i_last, end_off);
            end
        end
    end

    assign o_brk.cnt  = s.cnt;
    assign o_brk.off0 = s.off0;
    assign o_brk.off1 = s.off1;

    // Counters; the final byte returns everything to the start of a document
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_col         <= '0;
            r_line        <= '0;
            r_wc          <= '0;
            r_ws          <= '0;
            r_pages       <= utf8ww_pkg::PAGE_W'(1);
        end else if (i_adv) begin
            if (i_last) begin
                r_byte_offset <= '0;
                r_col         <= '0;
                r_line        <= '0;
                r_wc          <= '0;
                r_ws          <= '0;
                r_pages       <= utf8ww_pkg::PAGE_W'(1);
            end else begin
                r_byte_offset <= end_off;
                r_col         <= s.col;
                r_line        <= s.line;
                r_wc          <= s.wc;
                r_ws          <= s.ws;
                r_pages       <= s.pages;
            end
        end
    end

    a_page_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= utf8ww_pkg::PAGE_W'(utf8ww_pkg::MAX_PAGES) && r_pages != '0)
        else $error("page counter out of range");

    a_doc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> (r_byte_offset == '0 && r_col == '0 && r_wc == '0))
        else $error("state not cleared after final byte");

    a_offset_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_last) |=> (r_byte_offset == $past(r_byte_offset) + 32'd1))
        else $error("byte offset did not advance");

endmodule

FILE: rtl/utf8_word_wrap_paginator.sv
// Top level of the UTF-8 word-wrap paginator: input register, config registers,
// result queue. Depends on utf8ww_pkg, utf8ww_decode, utf8ww_layout.
//
// Usage:
//   Input channel (i_valid, i_data, o_stall) carries one text byte per beat,
//   with last_byte set on the final byte of a document. Output channel
//   (o_valid, o_data, i_stall) carries page-start offsets; each input byte
//   yields zero, one or two beats, last_of_run set on the final one.
//   Config channel (i_cfg_valid, i_cfg_index, i_cfg_data, o_cfg_ready) writes
//   line_columns (index 0) or page_rows (index 1); write only while idle.
// Order: an accepted byte waits in the input register until two queue entries are free;
//   its results are offered on o_valid from the cycle after the edge that processes it.
// Throughput: one byte per cycle while two queue entries are free, set by the
//   combinational decode and layout update against the held counters. Results drain
//   one beat per cycle while i_stall is low, from a four-entry queue.
// Reset: synchronous active-low i_rst_n clears all counters (first page at
//   offset zero is implied) and loads line_columns 38, page_rows 27.
// Stall: when i_stall holds the output, the queue fills and o_stall rises;
//   one byte waits in the input register meanwhile.
module utf8_word_wrap_paginator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  utf8ww_pkg::t_in_beat   i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output utf8ww_pkg::t_out_beat  o_data,
    input  logic                   i_stall,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    output logic                   o_cfg_ready
);

    logic                          r_in_valid;
    utf8ww_pkg::t_in_beat          r_in;
    logic [7:0]                    r_line_columns;
    logic [7:0]                    r_page_rows;
    utf8ww_pkg::t_out_beat         r_q [utf8ww_pkg::QDEPTH];
    logic [utf8ww_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [utf8ww_pkg::QCNT_W-1:0] r_cnt, n_cnt;
    logic                          fire, accept, pop;
    utf8ww_pkg::t_char             ch;
    utf8ww_pkg::t_brk              brk;

    // Handshakes
    assign fire        = r_in_valid &&
                         (r_cnt <= utf8ww_pkg::QCNT_W'(utf8ww_pkg::QDEPTH - 2));
    assign o_stall     = r_in_valid && !fire;
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_cnt != '0;
    assign pop         = o_valid && !i_stall;
    assign o_data      = r_q[r_rd];
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_data;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_columns <= utf8ww_pkg::LINE_COLUMNS_RST;
            r_page_rows    <= utf8ww_pkg::PAGE_ROWS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                utf8ww_pkg::CFG_LINE_COLUMNS: r_line_columns <= i_cfg_data;
                utf8ww_pkg::CFG_PAGE_ROWS:    r_page_rows    <= i_cfg_data;
                default:                      r_page_rows    <= r_page_rows;
            endcase
        end
    end

    utf8ww_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (fire),
        .i_byte  (r_in.data_byte),
        .i_last  (r_in.last_byte),
        .o_char  (ch)
    );

    utf8ww_layout u_layout (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (fire),
        .i_char         (ch),
        .i_last         (r_in.last_byte),
        .i_line_columns (r_line_columns),
        .i_page_rows    (r_page_rows),
        .o_brk          (brk)
    );

    // Result queue pointers and fill level
    always_comb begin
        n_cnt = r_cnt;
        if (fire) begin
            n_cnt = n_cnt + utf8ww_pkg::QCNT_W'(brk.cnt);
        end
        if (pop) begin
            n_cnt = n_cnt - utf8ww_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (fire) begin
                r_wr <= r_wr + utf8ww_pkg::QPTR_W'(brk.cnt);
            end
            if (pop) begin
                r_rd <= r_rd + utf8ww_pkg::QPTR_W'(1);
            end
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (fire && brk.cnt != 2'd0) begin
            r_q[r_wr] <= '{page_offset: brk.off0, last_of_run: (brk.cnt == 2'd1)};
            if (brk.cnt == 2'd2) begin
                r_q[r_wr + utf8ww_pkg::QPTR_W'(1)] <= '{page_offset: brk.off1,
                                                         last_of_run: 1'b1};
            end
        end
    end

    a_q_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= utf8ww_pkg::QCNT_W'(utf8ww_pkg::QDEPTH))
        else $error("result queue overflow");

    a_brk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> brk.cnt != 2'd3)
        else $error("too many breaks for one byte");

    a_q_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill level");

endmodule

FILE: dv/tb_utf8_word_wrap_paginator.sv
// Testbench of the UTF-8 word-wrap paginator: directed and random documents, checked
// beat by beat against a layout predictor kept in this file.
// Depends on utf8ww_pkg and utf8_word_wrap_paginator.
module tb_utf8_word_wrap_paginator;

    localparam int N_RANDOM   = 800;
    localparam int MAX_ERRS   = 10;
    localparam int TIMEOUT_TU = 10_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    utf8ww_pkg::t_in_beat  in_beat;
    logic                  in_stall;
    logic                  out_valid;
    utf8ww_pkg::t_out_beat out_beat;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid;
    logic                  cfg_index;
    logic [7:0]            cfg_data;
    logic                  cfg_ready;

    utf8_word_wrap_paginator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .i_data      (in_beat),
        .o_stall     (in_stall),
        .o_valid     (out_valid),
        .o_data      (out_beat),
        .i_stall     (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #5 clk = ~clk;

    // Predicted layout state
    logic [7:0]  line_cols;
    logic [7:0]  rows_per_page;
    int unsigned doc_pos, col_pos, row_in_page, word_len, word_begin;
    logic [7:0]  lead_b, second_b;
    int unsigned seq_have, seq_need, pages_cnt;
    int unsigned brk[4];
    int          brk_cnt;
    bit          at_end;
    int unsigned end_pos;

    // Expected page starts, oldest first
    utf8ww_pkg::t_out_beat page_starts_q[$];

    // Run statistics
    int mismatches  = 0;
    int bytes_in    = 0;
    int docs_done   = 0;
    int starts_seen = 0;
    int cfg_writes  = 0;
    int held_cycles = 0;

    // Idling controls
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    int hold_left  = 0;
    int rx_burst   = 0;

    logic [7:0] doc_bytes[$];

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= MAX_ERRS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void clear_doc();
        doc_pos     = 0;
        col_pos     = 0;
        row_in_page = 0;
        word_len    = 0;
        word_begin  = 0;
        lead_b      = '0;
        second_b    = '0;
        seq_have    = 0;
        seq_need    = 0;
        pages_cnt   = 1;
    endfunction

    // Record a page start unless it lies past the end of the document or the cap is hit
    function automatic void count_break(int unsigned off);
        if (!(at_end && off >= end_pos) && pages_cnt < utf8ww_pkg::MAX_PAGES) begin
            pages_cnt++;
            if (brk_cnt < 4) begin
                brk[brk_cnt] = off;
                brk_cnt++;
            end
        end
    endfunction

    function automatic void finish_line(int unsigned next_off);
        col_pos = 0;
        row_in_page++;
        if (row_in_page >= rows_per_page) begin
            row_in_page = 0;
            count_break(next_off);
        end
    endfunction

    // Place the pending word, wrapping first if it does not fit after a separator
    function automatic void commit_word();
        if (word_len != 0) begin
            if (col_pos > 0 && col_pos + 1 + word_len > line_cols)
                finish_line(word_begin);
            if (col_pos > 0)
                col_pos++;
            col_pos += word_len;
            word_len = 0;
        end
    endfunction

    function automatic void take_char(int unsigned cp, int unsigned off, int unsigned nb);
        if (cp == utf8ww_pkg::CP_LF) begin
            commit_word();
            finish_line(off + nb);
        end else if (cp == utf8ww_pkg::CP_SPACE || cp == utf8ww_pkg::CP_TAB ||
                     cp == utf8ww_pkg::CP_CR) begin
            commit_word();
        end else begin
            if (word_len == 0)
                word_begin = off;
            word_len++;
            // hard break of a word as wide as the line
            if (word_len >= line_cols)
                commit_word();
        end
    endfunction

    // One accepted text byte: decode, lay out, queue the page starts it causes
    function automatic void paginate_byte(logic [7:0] b, logic is_last);
        int unsigned           cur;
        int unsigned           cp;
        bit                    handled;
        int                    n;
        utf8ww_pkg::t_out_beat r;
        cur     = doc_pos;
        handled = 1'b0;
        at_end  = is_last;
        end_pos = cur + 1;
        brk_cnt = 0;

        if (seq_need > 0) begin
            if ((b & utf8ww_pkg::MASK_CONT) == utf8ww_pkg::TAG_CONT) begin
                if (seq_have == seq_need) begin
                    if (seq_need == 1)
                        cp = {lead_b[4:0], b[5:0]};
                    else if (seq_need == 2)
                        cp = {lead_b[3:0], second_b[5:0], b[5:0]};
                    else
                        cp = utf8ww_pkg::CP_QMARK;   // 4-byte form is one plain column
                    take_char(cp, cur - seq_need, seq_need + 1);
                    seq_need = 0;
                    seq_have = 0;
                end else begin
                    if (seq_have == 1)
                        second_b = b;
                    seq_have++;
                end
                handled = 1'b1;
            end else begin
                // broken sequence: drop it, the byte is taken fresh below
                seq_need = 0;
                seq_have = 0;
            end
        end

        if (!handled) begin
            if (b[7] == 1'b0) begin
                take_char(b, cur, 1);
            end else if ((b & utf8ww_pkg::MASK_LD2) == utf8ww_pkg::TAG_LD2) begin
                lead_b = b; seq_have = 1; seq_need = 1;
            end else if ((b & utf8ww_pkg::MASK_LD3) == utf8ww_pkg::TAG_LD3) begin
                lead_b = b; seq_have = 1; seq_need = 2;
            end else if ((b & utf8ww_pkg::MASK_LD4) == utf8ww_pkg::TAG_LD4) begin
                lead_b = b; seq_have = 1; seq_need = 3;
            end
        end

        // end of document: flush, close the line, start over
        if (is_last) begin
            commit_word();
            if (col_pos > 0)
                finish_line(end_pos);
            clear_doc();
        end else begin
            doc_pos = cur + 1;
        end

        n = (brk_cnt > 2) ? 2 : brk_cnt;
        for (int k = 0; k < n; k++) begin
            r.page_offset = brk[k];
            r.last_of_run = (k == n - 1);
            page_starts_q.push_back(r);
        end
    endfunction

    // Sample every handshake at the rising edge; all predictor updates happen here
    always @(posedge clk) begin : monitor
        utf8ww_pkg::t_out_beat want;
        if (!rst_n) begin
            line_cols     = utf8ww_pkg::LINE_COLUMNS_RST;
            rows_per_page = utf8ww_pkg::PAGE_ROWS_RST;
            clear_doc();
            page_starts_q.delete();
        end else begin
            if (out_valid && !out_stall) begin
                if (page_starts_q.size() == 0) begin
                    flag_error($sformatf("unexpected beat offset=%0d last=%0b",
                                         out_beat.page_offset, out_beat.last_of_run));
                end else begin
                    want = page_starts_q.pop_front();
                    starts_seen++;
                    if (out_beat.page_offset !== want.page_offset ||
                        out_beat.last_of_run !== want.last_of_run)
                        flag_error($sformatf("exp offset=%0d last=%0b, got offset=%0d last=%0b",
                                             want.page_offset, want.last_of_run,
                                             out_beat.page_offset, out_beat.last_of_run));
                end
            end
            if (in_valid && in_stall)
                held_cycles++;
            if (in_valid && !in_stall) begin
                paginate_byte(in_beat.data_byte, in_beat.last_byte);
                bytes_in++;
                if (in_beat.last_byte)
                    docs_done++;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == utf8ww_pkg::CFG_LINE_COLUMNS)
                    line_cols = cfg_data;
                else
                    rows_per_page = cfg_data;
                cfg_writes++;
            end
        end
    end

    // Receiver: long hold-off on request, else random stall bursts
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (rx_burst > 0) begin
            out_stall <= 1'b1;
            rx_burst--;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            out_stall <= 1'b1;
            rx_burst = $urandom_range(0, 14);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Offer one byte, optionally after an idle burst, and wait for its beat
    task automatic send_byte(logic [7:0] b, logic is_last);
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= utf8ww_pkg::t_in_beat'{data_byte: b, last_byte: is_last};
        do @(posedge clk); while (in_stall);
    endtask

    // Send doc_bytes as one document, last_byte on the final byte
    task automatic send_doc();
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    endtask

    // Stop sending, wait for every expected page start, then let the pipe empty
    task automatic settle();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (page_starts_q.size() != 0 && waited < 4000) begin
            @(posedge clk);
            waited++;
        end
        if (page_starts_q.size() != 0) begin
            flag_error($sformatf("%0d page starts never arrived, next offset=%0d",
                                 page_starts_q.size(), page_starts_q[0].page_offset));
            page_starts_q.delete();
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_layout(logic [7:0] cols, logic [7:0] rows);
        write_reg(utf8ww_pkg::CFG_LINE_COLUMNS, cols);
        write_reg(utf8ww_pkg::CFG_PAGE_ROWS, rows);
    endtask

    // Append one random token: mostly well-formed text, some noise
    task automatic add_token();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            len = $urandom_range(1, 10);
            repeat (len) begin
                if ($urandom_range(0, 5) == 0) begin
                    doc_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                    doc_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end else begin
                    doc_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
                end
            end
        end else if (pick < 60) begin
            case ($urandom_range(0, 2))
                0:       doc_bytes.push_back(utf8ww_pkg::CP_SPACE[7:0]);
                1:       doc_bytes.push_back(utf8ww_pkg::CP_TAB[7:0]);
                default: doc_bytes.push_back(utf8ww_pkg::CP_CR[7:0]);
            endcase
        end else if (pick < 70) begin
            doc_bytes.push_back(utf8ww_pkg::CP_LF[7:0]);
        end else if (pick < 78) begin
            // two-byte form, overlong leads included
            doc_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            doc_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 85) begin
            doc_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) doc_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 90) begin
            doc_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) doc_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else if (pick < 95) begin
            // possibly cut-off sequence: lead, maybe one continuation, then a plain byte
            doc_bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            if ($urandom_range(0, 1) == 0)
                doc_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            doc_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end else begin
            doc_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // UTF-8 decoding: 2-, 3-, 4-byte forms, overlong LF and space, stray and broken bytes
    task automatic test_decode_cases();
        set_layout(8'd4, 8'd1);
        doc_bytes = '{8'h61, 8'hC3, 8'hA9, 8'h20, 8'hF0, 8'h9F, 8'h98, 8'h80,
                      8'hC0, 8'h8A, 8'h80, 8'hFF, 8'hC3, 8'h41, 8'hE0, 8'h80,
                      8'hA0, 8'h00};
        send_doc();
        settle();
    endtask

    // Wrapping: two page starts from one LF, hard break, flush on the last byte
    task automatic test_wrap_cases();
        set_layout(8'd3, 8'd1);
        doc_bytes = '{8'h61, 8'h62, 8'h20, 8'h63, 8'h64, 8'h0A,
                      8'h61, 8'h62, 8'h63, 8'h64};
        send_doc();
        settle();
    endtask

    // Zero-valued registers, and a document ending on a pending lead byte
    task automatic test_zero_registers();
        set_layout(8'd0, 8'd0);
        doc_bytes = '{8'h61, 8'h20, 8'h62, 8'h09, 8'hC3};
        send_doc();
        settle();
    endtask

    // Receiver holds off while bytes keep coming, so the result queue backs up
    task automatic test_backpressure();
        set_layout(8'd1, 8'd1);
        hold_left = 300;
        doc_bytes.delete();
        repeat (60) doc_bytes.push_back(8'h78);
        send_doc();
        settle();
    endtask

    // Random documents over a sweep of layouts; no idling in the final stretch
    task automatic test_random_docs();
        logic [7:0] cols_set[9] = '{8'd1, 8'd255, 8'd0, 8'd4, 8'd8, 8'd12, 8'd255, 8'd2, 8'd38};
        logic [7:0] rows_set[9] = '{8'd1, 8'd1, 8'd0, 8'd2, 8'd3, 8'd1, 8'd255, 8'd255, 8'd2};
        int first_byte;
        int first_start;
        int phase;
        int doc_len;
        first_byte  = bytes_in;
        first_start = starts_seen;
        phase       = 0;
        while ((bytes_in - first_byte < N_RANDOM || starts_seen - first_start < 48)
               && phase < 200) begin
            if (phase < 9)
                set_layout(cols_set[phase], rows_set[phase]);
            else
                set_layout(8'($urandom_range(1, 20)), 8'($urandom_range(1, 4)));
            repeat (4) begin
                if (bytes_in - first_byte < N_RANDOM * 3 / 4) begin
                    tx_idle_en = ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end else begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                doc_len = $urandom_range(3, 40);
                doc_bytes.delete();
                while (doc_bytes.size() < doc_len)
                    add_token();
                send_doc();
            end
            settle();
            phase++;
        end
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_beat   = '0;
        cfg_valid = 1'b0;
        cfg_index = utf8ww_pkg::CFG_LINE_COLUMNS;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decode_cases();
        test_wrap_cases();
        test_zero_registers();
        test_backpressure();
        test_random_docs();
        settle();

        $display("Covered %0d bytes in %0d documents, %0d page starts checked.",
                 bytes_in, docs_done, starts_seen);
        $display("Layout registers written %0d times; input held off for %0d cycles.",
                 cfg_writes, held_cycles);
        if (mismatches == 0)
            $display("PASS utf8_word_wrap_paginator");
        else
            $display("FAIL utf8_word_wrap_paginator");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_TU);
        $display("FAIL utf8_word_wrap_paginator");
        $finish;
    end

endmodule

FILE: sim.f
rtl/utf8ww_pkg.sv
rtl/utf8ww_decode.sv
rtl/utf8ww_layout.sv
rtl/utf8_word_wrap_paginator.sv
dv/tb_utf8_word_wrap_paginator.sv
